[rtl/jmsc_pkg.sv]
// Shared types and constants for the JPEG marker structure check.
// Used by jmsc_parser and jpeg_marker_structure_check_unit; no dependencies.
package jmsc_pkg;

    localparam logic [7:0] BYTE_FF       = 8'hff;
    localparam logic [7:0] MARK_SOI      = 8'hd8;
    localparam logic [7:0] MARK_EOI      = 8'hd9;
    localparam logic [7:0] MARK_SOS      = 8'hda;
    localparam logic [7:0] MARK_TEM      = 8'h01;
    localparam logic [7:0] MARK_RST_LO   = 8'hd0;
    localparam logic [7:0] MARK_RST_HI   = 8'hd7;
    localparam logic [7:0] MARK_SOF_LO   = 8'hc0;
    localparam logic [7:0] MARK_SOF_HI   = 8'hcf;
    localparam logic [7:0] MARK_DHT      = 8'hc4;
    localparam logic [7:0] MARK_JPG      = 8'hc8;
    localparam logic [7:0] MARK_DAC      = 8'hcc;

    localparam int unsigned BYTE_W       = 8;
    localparam int unsigned LEN_W        = 16;
    localparam int unsigned SEEN_W       = 3;
    localparam logic [SEEN_W-1:0] SEEN_MIN = 3'd4;
    localparam logic [LEN_W-1:0]  LEN_MIN  = 16'd2;

    typedef enum logic [8:0] {
        PH_SOI_FF  = 9'b000000001,
        PH_SOI_D8  = 9'b000000010,
        PH_MARK_FF = 9'b000000100,
        PH_MARKER  = 9'b000001000,
        PH_LEN_HI  = 9'b000010000,
        PH_LEN_LO  = 9'b000100000,
        PH_SEG     = 9'b001000000,
        PH_SCAN    = 9'b010000000,
        PH_FAIL    = 9'b100000000
    } phase_t;

    typedef struct packed {
        logic [BYTE_W-1:0] data_byte;
        logic              last_byte;
    } item_t;

    function automatic logic is_frame_marker(input logic [BYTE_W-1:0] m);
        return (m >= MARK_SOF_LO) && (m <= MARK_SOF_HI) &&
               (m != MARK_DHT) && (m != MARK_JPG) && (m != MARK_DAC);
    endfunction

endpackage

[rtl/jpeg_marker_structure_check_unit.sv]
// Top level of the JPEG marker structure check: input register, parser, result register.
// Depends on jmsc_pkg and jmsc_parser.
//
//  Channel   Direction  Transaction carries
//  s_axis    in         one buffer byte (tdata), end of buffer (tlast)
//  m_axis    out        one verdict per buffer, well_formed in tdata[0]
//
// Each byte is held in the input register; the parser updates its state
// from that register, and a verdict enters the result register on the last byte.
// Sustained rate is one byte per cycle. aresetn is synchronous and clears all control
// state. The input register keeps taking bytes while a verdict waits; only a last
// byte meeting a full, stalled result register holds the input side.
module jpeg_marker_structure_check_unit (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,   // [7:0] data_byte
    input  logic       s_axis_tlast,   // last_byte
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata    // [0] well_formed, [7:1] zero
);
    import jmsc_pkg::*;

    logic  in_valid_reg;
    item_t in_item_reg;
    logic  out_valid_reg;
    logic  out_wf_reg;
    logic  advance;
    logic  verdict;

    // A byte leaves the input register unless it would produce a verdict that
    // has nowhere to go.
    assign advance       = in_valid_reg &&
                           (!in_item_reg.last_byte || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_axis_tready) begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            in_item_reg.data_byte <= s_axis_tdata;
            in_item_reg.last_byte <= s_axis_tlast;
        end
    end

    jmsc_parser u_parser (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .step_en     (advance),
        .item        (in_item_reg),
        .well_formed (verdict)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (advance && in_item_reg.last_byte) begin
            out_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance && in_item_reg.last_byte) begin
            out_wf_reg <= verdict;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {7'd0, out_wf_reg};

endmodule

[rtl/jmsc_parser.sv]
// Marker segment walker: parse state registers and the per-byte update.
// Depends on jmsc_pkg.
module jmsc_parser (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            step_en,      // consume one byte this cycle
    input  jmsc_pkg::item_t item,
    output logic            well_formed   // verdict, meaningful on a last byte
);
    import jmsc_pkg::*;

    phase_t              phase_reg, phase_next;
    logic                frame_seen_reg, frame_seen_next;
    logic                frame_pend_reg, frame_pend_next;
    logic [BYTE_W-1:0]   len_upper_reg, len_upper_next;
    logic [LEN_W-1:0]    seg_left_reg, seg_left_next;
    logic                prev_ff_reg, prev_ff_next;
    logic [SEEN_W-1:0]   seen_reg, seen_next;
    logic                hit;
    logic [LEN_W-1:0]    len;
    logic [LEN_W-1:0]    seg_dec;
    logic [BYTE_W-1:0]   b;

    assign b       = item.data_byte;
    assign len     = {len_upper_reg, b};
    assign seg_dec = (seg_left_reg != '0) ? seg_left_reg - 1'b1 : seg_left_reg;

    always_comb begin
        phase_next      = phase_reg;
        frame_seen_next = frame_seen_reg;
        frame_pend_next = frame_pend_reg;
        len_upper_next  = len_upper_reg;
        seg_left_next   = seg_left_reg;
        prev_ff_next    = prev_ff_reg;
        seen_next       = (seen_reg < SEEN_MIN) ? seen_reg + 1'b1 : seen_reg;
        hit             = 1'b0;

        case (phase_reg)
            PH_SOI_FF: begin
                phase_next = (b == BYTE_FF) ? PH_SOI_D8 : PH_FAIL;
            end
            PH_SOI_D8: begin
                phase_next = (b == MARK_SOI) ? PH_MARK_FF : PH_FAIL;
            end
            PH_MARK_FF: begin
                phase_next = (b == BYTE_FF) ? PH_MARKER : PH_FAIL;
            end
            PH_MARKER: begin
                if (b == BYTE_FF) begin
                    phase_next = PH_MARKER;
                end else if (b == MARK_EOI) begin
                    phase_next = PH_FAIL;
                end else if (b == MARK_SOS) begin
                    if (frame_seen_reg) begin
                        phase_next   = PH_SCAN;
                        prev_ff_next = 1'b0;
                    end else begin
                        phase_next = PH_FAIL;
                    end
                end else if (b == MARK_TEM || (b >= MARK_RST_LO && b <= MARK_RST_HI)) begin
                    phase_next = PH_MARK_FF;
                end else begin
                    frame_pend_next = is_frame_marker(b);
                    phase_next      = PH_LEN_HI;
                end
            end
            PH_LEN_HI: begin
                len_upper_next = b;
                phase_next     = PH_LEN_LO;
            end
            PH_LEN_LO: begin
                if (len < LEN_MIN) begin
                    phase_next = PH_FAIL;
                end else begin
                    if (frame_pend_reg) begin
                        frame_seen_next = 1'b1;
                    end
                    frame_pend_next = 1'b0;
                    seg_left_next   = len - LEN_MIN;
                    phase_next      = (len == LEN_MIN) ? PH_MARK_FF : PH_SEG;
                end
            end
            PH_SEG: begin
                seg_left_next = seg_dec;
                if (seg_dec == '0) begin
                    phase_next = PH_MARK_FF;
                end
            end
            PH_SCAN: begin
                // The first FF D9 pair in the scan must close the buffer.
                if (prev_ff_reg && b == MARK_EOI) begin
                    if (item.last_byte) begin
                        hit = 1'b1;
                    end else begin
                        phase_next = PH_FAIL;
                    end
                end
                prev_ff_next = (b == BYTE_FF);
            end
            default: begin
                phase_next = PH_FAIL;
            end
        endcase
    end

    assign well_formed = hit && (phase_next == PH_SCAN) && (seen_next >= SEEN_MIN);

    // Control state returns to reset after every last byte.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg      <= PH_SOI_FF;
            frame_seen_reg <= 1'b0;
            frame_pend_reg <= 1'b0;
            seg_left_reg   <= '0;
            prev_ff_reg    <= 1'b0;
            seen_reg       <= '0;
        end else if (step_en) begin
            if (item.last_byte) begin
                phase_reg      <= PH_SOI_FF;
                frame_seen_reg <= 1'b0;
                frame_pend_reg <= 1'b0;
                seg_left_reg   <= '0;
                prev_ff_reg    <= 1'b0;
                seen_reg       <= '0;
            end else begin
                phase_reg      <= phase_next;
                frame_seen_reg <= frame_seen_next;
                frame_pend_reg <= frame_pend_next;
                seg_left_reg   <= seg_left_next;
                prev_ff_reg    <= prev_ff_next;
                seen_reg       <= seen_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (step_en) begin
            len_upper_reg <= len_upper_next;
        end
    end

endmodule
